FILE: design/fucs_pkg.sv
// Shared types and constants for the first-unique-byte stream core.
package fucs_pkg;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef struct packed {
    logic [7:0] char_in;
    logic       restart;
  } fucs_in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] first_unique;
  } fucs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_POP_FIFO,
    ST_POP_CNT,
    ST_POP_CHK,
    ST_EMIT
  } fucs_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic fifo_rd;
    logic cnt_rd;
    logic pop_chk;
    logic emit;
  } fucs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic drop;
    logic upd_pop;
    logic dup;
    logic last;
    logic out_free;
  } fucs_stat_t;

endpackage

FILE: design/fucs_ctrl.sv
// Controller state machine for the first-unique-byte stream core.
module fucs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fucs_pkg::fucs_stat_t st,
  output fucs_pkg::fucs_cmd_t  cmd
);

  fucs_pkg::fucs_state_t state, state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fucs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through count update, head pops and result hand-off
  always_comb begin
    state_next = state;
    unique case (state)
      fucs_pkg::ST_IDLE: begin
        if (in_valid && !st.drop) begin
          state_next = fucs_pkg::ST_UPDATE;
        end
      end
      fucs_pkg::ST_UPDATE: begin
        if (st.upd_pop && !st.last) begin
          state_next = fucs_pkg::ST_POP_FIFO;
        end else begin
          state_next = fucs_pkg::ST_EMIT;
        end
      end
      fucs_pkg::ST_POP_FIFO: state_next = fucs_pkg::ST_POP_CNT;
      fucs_pkg::ST_POP_CNT:  state_next = fucs_pkg::ST_POP_CHK;
      fucs_pkg::ST_POP_CHK: begin
        if (st.dup && !st.last) begin
          state_next = fucs_pkg::ST_POP_FIFO;
        end else begin
          state_next = fucs_pkg::ST_EMIT;
        end
      end
      fucs_pkg::ST_EMIT: begin
        if (st.out_free) begin
          state_next = fucs_pkg::ST_IDLE;
        end
      end
      default: state_next = fucs_pkg::ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      fucs_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      fucs_pkg::ST_UPDATE:   cmd.update  = 1'b1;
      fucs_pkg::ST_POP_FIFO: cmd.fifo_rd = 1'b1;
      fucs_pkg::ST_POP_CNT:  cmd.cnt_rd  = 1'b1;
      fucs_pkg::ST_POP_CHK:  cmd.pop_chk = 1'b1;
      fucs_pkg::ST_EMIT:     cmd.emit    = st.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

FILE: design/fucs_dp.sv
// Datapath: count table, candidate queue, pointers and result register.
module fucs_dp #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  fucs_pkg::fucs_in_t   in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output fucs_pkg::fucs_out_t  out_data,
  input  fucs_pkg::fucs_cmd_t  cmd,
  output fucs_pkg::fucs_stat_t st
);

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam int UW = $clog2(ALPHABET_SIZE + 1);

  logic [1:0]    count_mem [ALPHABET_SIZE];
  logic [AW-1:0] fifo_mem  [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] cnt_valid;

  logic          skip_space;
  logic [AW-1:0] ch;
  logic [AW-1:0] head, tail, head_val, fifo_rd;
  logic [UW-1:0] used;
  logic [1:0]    cnt_rdata;
  logic          cnt_rvalid;
  logic [1:0]    cnt_eff;
  logic [1:0]    cnt_sat;
  logic [AW-1:0] cnt_addr;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(ALPHABET_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  // Hold the space-skip register
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_space <= 1'b1;
    end else if (cfg_we) begin
      skip_space <= cfg_data;
    end
  end

  // Drop spaces when skipping and bytes outside the alphabet
  assign st.drop = (skip_space && (in_data.char_in == fucs_pkg::SPACE_CHAR)) ||
                   ({1'b0, in_data.char_in} >= 9'(ALPHABET_SIZE));

  // Count read: the incoming byte on accept, the queue head byte when popping
  assign cnt_addr = cmd.accept ? in_data.char_in[AW-1:0] : fifo_rd;

  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.cnt_rd) begin
      cnt_rdata  <= count_mem[cnt_addr];
      cnt_rvalid <= cnt_valid[cnt_addr] && !(cmd.accept && in_data.restart);
    end
  end

  assign cnt_eff = cnt_rvalid ? cnt_rdata : 2'd0;
  assign cnt_sat = (cnt_eff >= 2'd2) ? 2'd2 : cnt_eff + 2'd1;

  // Count table write
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      count_mem[ch] <= cnt_sat;
    end
  end

  // Entry valid bits: cleared by reset and restart
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (cmd.accept && in_data.restart) begin
      cnt_valid <= '0;
    end else if (cmd.update) begin
      cnt_valid[ch] <= 1'b1;
    end
  end

  // Candidate queue write and head read
  always_ff @(posedge clk) begin
    if (cmd.update && (cnt_eff == 2'd0)) begin
      fifo_mem[tail] <= ch;
    end
    if (cmd.fifo_rd) begin
      fifo_rd <= fifo_mem[head];
    end
  end

  // Latch the byte of the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch <= in_data.char_in[AW-1:0];
    end
  end

  assign st.upd_pop = (cnt_eff == 2'd1) && (used != '0) && (head_val == ch);
  assign st.dup     = cnt_eff >= 2'd2;
  assign st.last    = (used == UW'(1));
  assign st.out_free = !out_valid || out_ready;

  // Queue pointers, fill count and head byte
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      used <= '0;
    end else if (cmd.accept && in_data.restart) begin
      head <= '0;
      tail <= '0;
      used <= '0;
    end else if (cmd.update) begin
      if (cnt_eff == 2'd0) begin
        tail <= ptr_inc(tail);
        used <= used + 1'b1;
        if (used == '0) begin
          head_val <= ch;
        end
      end else if (st.upd_pop) begin
        head <= ptr_inc(head);
        used <= used - 1'b1;
      end
    end else if (cmd.pop_chk) begin
      if (st.dup) begin
        head <= ptr_inc(head);
        used <= used - 1'b1;
      end else begin
        head_val <= fifo_rd;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.found        <= (used != '0);
      out_data.first_unique <= (used != '0) ? 8'(head_val) : 8'd0;
    end
  end

endmodule

FILE: design/first_unique_char_stream_core.sv
// Top level: first non-repeating byte of a stream, controller plus datapath.
// After accept, the count of the byte is updated and the result is loaded; each later
// queue head that needs a check adds a queue read, a count read and a compare first.
// Items do not overlap: input is taken again only after the result is loaded, and an
// output stall holds it back; a dropped byte is taken without leaving the idle state.
// Reset (synchronous, active high) clears counts, queue and sets skip_space.
module first_unique_char_stream_core #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  fucs_pkg::fucs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fucs_pkg::fucs_out_t out_data
);

  fucs_pkg::fucs_cmd_t  cmd;
  fucs_pkg::fucs_stat_t st;

  fucs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fucs_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  // A not-found result carries a zero byte
  a_zero_when_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.first_unique == 8'd0)
    else $error("not-found result with non-zero byte");

  // A counted item blocks further input until its result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !st.drop |=> !in_ready)
    else $error("input taken while an item is in work");

  // Loading the result register always presents a result
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule
